FILE: rtl/closest_colour_pixel_tracker_defines.svh
// Assertion macros for the closest colour pixel tracker.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef CLOSEST_COLOUR_PIXEL_TRACKER_DEFINES_SVH
`define CLOSEST_COLOUR_PIXEL_TRACKER_DEFINES_SVH

// condition holds on every clock out of reset
`define CCPT_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CCPT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CCPT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ccpt_pkg.sv
// Shared types, constants and helpers for the closest colour pixel tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ccpt_pkg;

  localparam int NUM_TARGETS = 3;
  localparam int COLOR_W     = 8;
  localparam int POS_W       = 11;
  localparam int SQ_W        = 16;
  localparam int DSQ_W       = 18;
  localparam int THR_W       = 9;
  localparam int RGB_W       = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int DEF_MAX_COLUMNS = 2048;
  localparam int DEF_MAX_ROWS    = 2048;

  localparam logic [SQ_W-1:0]  RESET_BEST_SQ = 16'd65025;

  localparam logic [RGB_W-1:0] RST_TARGET_ONE   = 24'hFF0000;
  localparam logic [RGB_W-1:0] RST_TARGET_TWO   = 24'h00FF00;
  localparam logic [RGB_W-1:0] RST_TARGET_THREE = 24'h0000FF;
  localparam int RST_THR_ONE   = 150;
  localparam int RST_THR_TWO   = 175;
  localparam int RST_THR_THREE = 150;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_ONE      = 3'd0,
    REG_TARGET_TWO      = 3'd1,
    REG_TARGET_THREE    = 3'd2,
    REG_THRESHOLD_ONE   = 3'd3,
    REG_THRESHOLD_TWO   = 3'd4,
    REG_THRESHOLD_THREE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_red;
    logic [COLOR_W-1:0] pixel_green;
    logic [COLOR_W-1:0] pixel_blue;
    logic [POS_W-1:0]   column;
    logic [POS_W-1:0]   row;
    logic               first_of_frame;
    logic               last_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [POS_W-1:0] one_column;
    logic [POS_W-1:0] one_row;
    logic [POS_W-1:0] two_column;
    logic [POS_W-1:0] two_row;
    logic [POS_W-1:0] three_column;
    logic [POS_W-1:0] three_row;
    logic             one_present;
    logic             two_present;
    logic             three_present;
  } result_t;

  // target colors and squared presence thresholds
  typedef struct packed {
    logic [NUM_TARGETS-1:0][RGB_W-1:0] rgb;
    logic [NUM_TARGETS-1:0][DSQ_W-1:0] thr_sq;
  } target_cfg_t;

  // per-target channel squares plus the pixel's position and frame marks
  typedef struct packed {
    logic [NUM_TARGETS-1:0][2:0][SQ_W-1:0] sq;
    logic [POS_W-1:0]                      column;
    logic [POS_W-1:0]                      row;
    logic                                  first;
    logic                                  last;
    logic                                  in_range;
  } dist_t;

  function automatic logic [SQ_W-1:0] diff_sq(logic [COLOR_W-1:0] a,
                                               logic [COLOR_W-1:0] b);
    logic [COLOR_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/closest_colour_pixel_tracker.sv
// A pixel beat is registered in the input stage, then in the difference stage, and then
// updates the trackers; a frame-end beat loads the result register and out_valid with them.
// Throughput: one pixel per cycle; input stalls only while a frame-end beat
// waits for the result register, which holds one unread frame result.
// Reset (rst_n low, synchronous): pipeline and result emptied, minima set to 65025,
// positions and present flags cleared, targets and thresholds to defaults.
`timescale 1ns / 1ps
`default_nettype none

module closest_colour_pixel_tracker #(
  parameter int MAX_COLUMNS = ccpt_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ccpt_pkg::DEF_MAX_ROWS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ccpt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ccpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire ccpt_pkg::pixel_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output ccpt_pkg::result_t                     out_data
);
  import ccpt_pkg::*;

  target_cfg_t tcfg;
  dist_t       s2;
  logic        s2_valid;
  logic        hold;

  ccpt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .tcfg      (tcfg)
  );

  ccpt_dist #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .tcfg     (tcfg),
    .hold     (hold),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  ccpt_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .tcfg      (tcfg),
    .hold      (hold),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/ccpt_cfg.sv
// Configuration registers: target colors and squared thresholds.
// Depends on ccpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccpt_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ccpt_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [ccpt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output ccpt_pkg::target_cfg_t                 tcfg
);
  import ccpt_pkg::*;

  logic [NUM_TARGETS-1:0][RGB_W-1:0] rgb_r;
  logic [NUM_TARGETS-1:0][DSQ_W-1:0] thr_sq_r;
  logic [THR_W-1:0]                  thr;
  logic [DSQ_W-1:0]                  wr_sq;

  // threshold is squared once at write time
  assign thr   = cfg_wdata[THR_W-1:0];
  assign wr_sq = DSQ_W'(thr) * DSQ_W'(thr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rgb_r[0]    <= RST_TARGET_ONE;
      rgb_r[1]    <= RST_TARGET_TWO;
      rgb_r[2]    <= RST_TARGET_THREE;
      thr_sq_r[0] <= DSQ_W'(RST_THR_ONE * RST_THR_ONE);
      thr_sq_r[1] <= DSQ_W'(RST_THR_TWO * RST_THR_TWO);
      thr_sq_r[2] <= DSQ_W'(RST_THR_THREE * RST_THR_THREE);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_TARGET_ONE:      rgb_r[0]    <= cfg_wdata[RGB_W-1:0];
        REG_TARGET_TWO:      rgb_r[1]    <= cfg_wdata[RGB_W-1:0];
        REG_TARGET_THREE:    rgb_r[2]    <= cfg_wdata[RGB_W-1:0];
        REG_THRESHOLD_ONE:   thr_sq_r[0] <= wr_sq;
        REG_THRESHOLD_TWO:   thr_sq_r[1] <= wr_sq;
        REG_THRESHOLD_THREE: thr_sq_r[2] <= wr_sq;
        default: ;
      endcase
    end
  end

  assign tcfg.rgb    = rgb_r;
  assign tcfg.thr_sq = thr_sq_r;

endmodule

`default_nettype wire

FILE: rtl/ccpt_dist.sv
// Input register and per-channel squared differences for all targets.
// Depends on ccpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccpt_dist #(
  parameter int MAX_COLUMNS = ccpt_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = ccpt_pkg::DEF_MAX_ROWS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire ccpt_pkg::pixel_t      in_data,
  input  wire ccpt_pkg::target_cfg_t tcfg,
  input  wire logic                  hold,
  output logic                       s2_valid,
  output ccpt_pkg::dist_t            s2
);
  import ccpt_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  pixel_t   s1_r;
  logic     s2_valid_r, s2_valid_nxt;
  dist_t    s2_r, s2_nxt;
  logic     accept;

  // the input stage can still fill while the stage below holds
  assign in_stall = hold & s1_valid_r;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (!hold) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    s2_valid_nxt = hold ? s2_valid_r : s1_valid_r;
  end

  always_comb begin
    for (int t = 0; t < NUM_TARGETS; t++) begin
      s2_nxt.sq[t][0] = diff_sq(s1_r.pixel_red,   tcfg.rgb[t][23:16]);
      s2_nxt.sq[t][1] = diff_sq(s1_r.pixel_green, tcfg.rgb[t][15:8]);
      s2_nxt.sq[t][2] = diff_sq(s1_r.pixel_blue,  tcfg.rgb[t][7:0]);
    end
    s2_nxt.column   = s1_r.column;
    s2_nxt.row      = s1_r.row;
    s2_nxt.first    = s1_r.first_of_frame;
    s2_nxt.last     = s1_r.last_of_frame;
    s2_nxt.in_range = (32'(s1_r.column) < MAX_COLUMNS) && (32'(s1_r.row) < MAX_ROWS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    if (!hold) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2       = s2_r;

endmodule

`default_nettype wire

FILE: rtl/ccpt_track.sv
// Running minimum and presence tracking per target, plus the result register.
// Depends on ccpt_pkg and closest_colour_pixel_tracker_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "closest_colour_pixel_tracker_defines.svh"

module ccpt_track (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  s2_valid,
  input  wire ccpt_pkg::dist_t       s2,
  input  wire ccpt_pkg::target_cfg_t tcfg,
  output logic                       hold,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output ccpt_pkg::result_t          out_data
);
  import ccpt_pkg::*;

  logic [NUM_TARGETS-1:0][SQ_W-1:0]  best_sq_r, best_sq_nxt;
  logic [NUM_TARGETS-1:0][POS_W-1:0] col_r, col_nxt;
  logic [NUM_TARGETS-1:0][POS_W-1:0] row_r, row_nxt;
  logic [NUM_TARGETS-1:0]            flag_r, flag_nxt;
  logic [NUM_TARGETS-1:0][DSQ_W-1:0] dsq;
  logic                              out_valid_r, out_valid_nxt;
  result_t                           out_r, out_nxt;
  logic                              out_free;
  logic                              upd;
  logic                              emit;
  logic                              best_in_range;
  logic                              out_agrees;

  // a frame-end beat waits only if the result register is still occupied
  assign out_free = ~out_valid_r | ~out_stall;
  assign hold     = s2_valid & s2.last & ~out_free;
  assign upd      = s2_valid & ~hold;

  always_comb begin
    for (int t = 0; t < NUM_TARGETS; t++) begin
      dsq[t] = DSQ_W'(s2.sq[t][0]) + DSQ_W'(s2.sq[t][1]) + DSQ_W'(s2.sq[t][2]);
      best_sq_nxt[t] = s2.first ? RESET_BEST_SQ : best_sq_r[t];
      flag_nxt[t]    = s2.first ? 1'b0 : flag_r[t];
      col_nxt[t]     = col_r[t];
      row_nxt[t]     = row_r[t];
      if (s2.in_range) begin
        // strict compare: ties keep the earlier pixel
        if (dsq[t] < DSQ_W'(best_sq_nxt[t])) begin
          best_sq_nxt[t] = dsq[t][SQ_W-1:0];
          col_nxt[t]     = s2.column;
          row_nxt[t]     = s2.row;
        end
        if (dsq[t] < tcfg.thr_sq[t]) begin
          flag_nxt[t] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_nxt.one_column    = col_nxt[0];
    out_nxt.one_row       = row_nxt[0];
    out_nxt.two_column    = col_nxt[1];
    out_nxt.two_row       = row_nxt[1];
    out_nxt.three_column  = col_nxt[2];
    out_nxt.three_row     = row_nxt[2];
    out_nxt.one_present   = flag_nxt[0];
    out_nxt.two_present   = flag_nxt[1];
    out_nxt.three_present = flag_nxt[2];
    if (upd && s2.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TARGETS; t++) begin
        best_sq_r[t] <= RESET_BEST_SQ;
        col_r[t]     <= '0;
        row_r[t]     <= '0;
        flag_r[t]    <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (upd) begin
        best_sq_r <= best_sq_nxt;
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        flag_r    <= flag_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd && s2.last) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign emit          = upd & s2.last;
  assign best_in_range = (best_sq_r[0] <= RESET_BEST_SQ) && (best_sq_r[1] <= RESET_BEST_SQ)
                         && (best_sq_r[2] <= RESET_BEST_SQ);
  assign out_agrees    = (out_r.one_column == col_r[0]) && (out_r.two_row == row_r[1])
                         && (out_r.three_present == flag_r[2]);

  `CCPT_ASSERT_ALWAYS(a_best_bound, best_in_range, "best distance above frame reset value")
  `CCPT_ASSERT_IMP(a_rise_from_last, $rose(out_valid_r), $past(emit), "result without frame end")
  `CCPT_ASSERT_NEXT(a_result_matches_state, emit, out_agrees, "result differs from state")
  `CCPT_ASSERT_NEXT(a_hold_keeps_state, hold, $stable({best_sq_r, flag_r}), "state moved in hold")

endmodule

`default_nettype wire

FILE: test/tb_closest_colour_pixel_tracker.sv
// Self-checking bench for the closest colour pixel tracker: random and directed pixel
// frames, a built-in tracker that predicts each frame result, random valid/stall gaps.
// Depends on ccpt_pkg and closest_colour_pixel_tracker.
`timescale 1ns / 1ps

module tb_closest_colour_pixel_tracker;
  import ccpt_pkg::*;

  localparam int PHASES         = 6;
  localparam int PHASE_PIXELS   = 240;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int COL_LIMIT      = 2048;
  localparam int ROW_LIMIT      = 2048;
  localparam int UNREACHED_SQ   = 65025;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  pixel_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  result_t out_data;

  closest_colour_pixel_tracker u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tracker copy: settings and per-target running state
  logic [23:0] tgt_rgb [3] = '{24'hFF0000, 24'h00FF00, 24'h0000FF};
  logic [8:0] tgt_thr [3] = '{9'd150, 9'd175, 9'd150};
  int unsigned best_sq [3] = '{UNREACHED_SQ, UNREACHED_SQ, UNREACHED_SQ};
  logic [10:0] best_col [3] = '{11'd0, 11'd0, 11'd0};
  logic [10:0] best_row [3] = '{11'd0, 11'd0, 11'd0};
  bit seen [3] = '{1'b0, 1'b0, 1'b0};

  pixel_t pixel_q [$];
  result_t frame_result_q [$];
  int errors = 0;
  int in_gap = 0;
  bit in_calm = 1'b0;
  int stall_left = 0;
  bit out_calm = 1'b0;
  int quiet_cycles = 0;

  function automatic bit track_pixel(input pixel_t p, output result_t r);
    logic [7:0] pix [3];
    int unsigned dsq;
    int d;
    pix[0] = p.pixel_red;
    pix[1] = p.pixel_green;
    pix[2] = p.pixel_blue;
    if (p.first_of_frame) begin
      for (int t = 0; t < 3; t++) begin
        best_sq[t] = UNREACHED_SQ;
        seen[t] = 1'b0;
      end
    end
    if (p.column < COL_LIMIT && p.row < ROW_LIMIT) begin
      for (int t = 0; t < 3; t++) begin
        dsq = 0;
        for (int k = 0; k < 3; k++) begin
          d = int'(pix[k]) - int'(tgt_rgb[t][23-8*k -: 8]);
          dsq += d * d;
        end
        // ties keep the earlier pixel
        if (dsq < best_sq[t]) begin
          best_sq[t] = dsq;
          best_col[t] = p.column;
          best_row[t] = p.row;
        end
        if (dsq < int'(tgt_thr[t]) * int'(tgt_thr[t])) seen[t] = 1'b1;
      end
    end
    r.one_column    = best_col[0];
    r.one_row       = best_row[0];
    r.two_column    = best_col[1];
    r.two_row       = best_row[1];
    r.three_column  = best_col[2];
    r.three_row     = best_row[2];
    r.one_present   = seen[0];
    r.two_present   = seen[1];
    r.three_present = seen[2];
    return p.last_of_frame;
  endfunction

  function automatic void push_pixel(logic [23:0] rgb, logic [10:0] col, logic [10:0] row,
                                     bit first, bit last);
    pixel_t p;
    p.pixel_red      = rgb[23:16];
    p.pixel_green    = rgb[15:8];
    p.pixel_blue     = rgb[7:0];
    p.column         = col;
    p.row            = row;
    p.first_of_frame = first;
    p.last_of_frame  = last;
    pixel_q.push_back(p);
  endfunction

  function automatic void check_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_TARGET_THREE) tgt_rgb[idx] = data;
    else if (idx <= REG_THRESHOLD_THREE) tgt_thr[idx - REG_THRESHOLD_ONE] = data[8:0];
  endtask

  // pixels without a frame end leave no trace, so pad past the pipeline
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || frame_result_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // pixel driver; the tracker copy advances on every accepted beat
  always @(posedge clk) begin : drive_pixels
    result_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (track_pixel(in_data, want)) frame_result_q.push_back(want);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          in_data <= pixel_q.pop_front();
          in_valid <= 1'b1;
          in_gap <= in_calm ? 0 : $urandom_range(0, 5);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 47) == 0) in_calm <= !in_calm;
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : watch_results
    result_t want;
    int k;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frame_result_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          want = frame_result_q.pop_front();
          check_field("one_column", want.one_column, out_data.one_column);
          check_field("one_row", want.one_row, out_data.one_row);
          check_field("two_column", want.two_column, out_data.two_column);
          check_field("two_row", want.two_row, out_data.two_row);
          check_field("three_column", want.three_column, out_data.three_column);
          check_field("three_row", want.three_row, out_data.three_row);
          check_field("one_present", 11'(want.one_present), 11'(out_data.one_present));
          check_field("two_present", 11'(want.two_present), 11'(out_data.two_present));
          check_field("three_present", 11'(want.three_present),
                      11'(out_data.three_present));
        end
        k = out_calm ? 0 : $urandom_range(0, 5);
        stall_left <= k;
        out_stall <= (k != 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end
      if ($urandom_range(0, 15) == 0) out_calm <= !out_calm;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int w, h, issued, t, k, off;
    bit drop_first, drop_last;
    logic [10:0] c0, r0;
    logic [23:0] colour, prev;
    logic [23:0] rgb [3];
    logic [8:0] thr [3];

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset targets
    push_pixel(24'hFF0000, 11'd2047, 11'd2047, 1'b1, 1'b1);
    // no pixel beats the reset minimum (each ties or exceeds it): old positions stay, no flags
    push_pixel(24'h00FFFF, 11'd5, 11'd1, 1'b1, 1'b0);
    push_pixel(24'hFF00FF, 11'd6, 11'd1, 1'b0, 1'b0);
    push_pixel(24'hFFFF00, 11'd7, 11'd1, 1'b0, 1'b1);
    // equal distances, then distances right at and just inside the thresholds
    push_pixel(24'h000000, 11'd0, 11'd0, 1'b1, 1'b0);
    push_pixel(24'h10F010, 11'd1, 11'd0, 1'b0, 1'b0);
    push_pixel(24'h10F010, 11'd2, 11'd0, 1'b0, 1'b0);
    push_pixel(24'h005000, 11'd3, 11'd0, 1'b0, 1'b0);
    push_pixel(24'h000069, 11'd4, 11'd0, 1'b0, 1'b0);
    push_pixel(24'h00006A, 11'd5, 11'd0, 1'b0, 1'b0);
    push_pixel(24'h6A0000, 11'd6, 11'd0, 1'b0, 1'b0);
    push_pixel(24'h690000, 11'd7, 11'd0, 1'b0, 1'b1);
    // stray beats outside any frame, then a frame with no start mark
    push_pixel(24'hFFFFFF, 11'd1024, 11'd512, 1'b0, 1'b0);
    push_pixel(24'h55AA55, 11'd1365, 11'd682, 1'b0, 1'b0);
    push_pixel(24'hFE0101, 11'd700, 11'd300, 1'b0, 1'b0);
    push_pixel(24'hAA55AA, 11'd701, 11'd300, 1'b0, 1'b1);
    push_pixel(24'h000000, 11'd0, 11'd0, 1'b1, 1'b1);
    push_pixel(24'h0000FF, 11'd1023, 11'd2046, 1'b1, 1'b0);
    push_pixel(24'h00FF00, 11'd2046, 11'd1023, 1'b0, 1'b0);
    push_pixel(24'h0000FF, 11'd1, 11'd2047, 1'b0, 1'b1);
    wait_idle();

    for (int phase = 1; phase <= PHASES; phase++) begin
      case (phase)
        1: begin
          rgb = '{24'h000000, 24'hFFFFFF, 24'($urandom)};
          thr = '{9'd0, 9'd511, 9'd442};
        end
        2: begin
          rgb = '{24'hFFFFFF, 24'h000000, 24'h7F807F};
          thr = '{9'd442, 9'd1, 9'd0};
        end
        default: begin
          for (t = 0; t < 3; t++) begin
            rgb[t] = 24'($urandom);
            thr[t] = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                                 : 9'($urandom_range(20, 260));
          end
        end
      endcase
      for (t = 0; t < 3; t++) write_reg(CFG_IDX_W'(REG_TARGET_ONE + t), rgb[t]);
      for (t = 0; t < 3; t++) begin
        write_reg(CFG_IDX_W'(REG_THRESHOLD_ONE + t), {15'($urandom), thr[t]});
      end
      if (phase == 1) begin
        // indexes past the register map must not disturb anything
        write_reg(SPARE_IDX_LO, CFG_DATA_W'($urandom));
        write_reg(SPARE_IDX_HI, CFG_DATA_W'($urandom));
      end

      issued = 0;
      prev = 24'($urandom);
      while (issued < PHASE_PIXELS) begin
        if ($urandom_range(0, 19) == 0) begin
          colour = 24'($urandom);
          push_pixel(colour, 11'($urandom), 11'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          issued++;
        end
        w = $urandom_range(1, 8);
        h = $urandom_range(1, 5);
        c0 = 11'($urandom_range(0, 2048 - w));
        r0 = 11'($urandom_range(0, 2048 - h));
        drop_first = ($urandom_range(0, 11) == 0);
        drop_last = ($urandom_range(0, 11) == 0);
        for (int y = 0; y < h; y++) begin
          for (int x = 0; x < w; x++) begin
            case ($urandom_range(0, 9))
              0, 1, 2: colour = 24'($urandom);
              3, 4, 5: begin
                t = $urandom_range(0, 2);
                k = $urandom_range(0, 40);
                for (int c = 0; c < 3; c++) begin
                  off = int'(tgt_rgb[t][8*c +: 8]) + int'($urandom_range(0, 2 * k)) - k;
                  colour[8*c +: 8] = (off < 0) ? 8'd0 : (off > 255) ? 8'd255 : off[7:0];
                end
              end
              6: colour = prev;
              7: colour = ~tgt_rgb[$urandom_range(0, 2)];
              8: begin
                // one channel off by the threshold or one less
                t = $urandom_range(0, 2);
                k = $urandom_range(0, 2);
                off = int'(tgt_thr[t]) - int'($urandom_range(0, 1));
                colour = tgt_rgb[t];
                if (off >= 0 && off <= 255) begin
                  if (int'(colour[8*k +: 8]) + off <= 255)
                    colour[8*k +: 8] = colour[8*k +: 8] + off[7:0];
                  else if (int'(colour[8*k +: 8]) >= off)
                    colour[8*k +: 8] = colour[8*k +: 8] - off[7:0];
                end
              end
              default: colour = tgt_rgb[$urandom_range(0, 2)];
            endcase
            push_pixel(colour, 11'(c0 + x), 11'(r0 + y), (x == 0 && y == 0 && !drop_first),
                       (x == w - 1 && y == h - 1 && !drop_last));
            prev = colour;
            issued++;
          end
        end
      end
      wait_idle();
    end

    if (errors == 0 && frame_result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
